/* hdl/spq_pkg.sv */
// Package with the shared types and constants of the stable priority queue.
package spq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FieldPrioW  = 8;
  localparam int unsigned FieldCountW = 5;
  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefPrioBits = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                    op;
    logic signed [DataW-1:0] msg_data;
    logic [FieldPrioW-1:0]  prio;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] out_data;
    logic [FieldPrioW-1:0]   out_prio;
    logic [FieldCountW-1:0]  count;
  } out_item_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// One storage cell of the sorted queue chain, holding one entry and its valid bit.
module spq_cell #(
  parameter int unsigned PRIO_BITS = spq_pkg::DefPrioBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::cell_ctrl_t       ctrl_i,
  input  logic [spq_pkg::DataW-1:0] new_data_i,
  input  logic [PRIO_BITS-1:0]      new_prio_i,
  input  logic                      left_ins_i,
  input  logic                      left_valid_i,
  input  logic [spq_pkg::DataW-1:0] left_data_i,
  input  logic [PRIO_BITS-1:0]      left_prio_i,
  input  logic                      right_valid_i,
  input  logic [spq_pkg::DataW-1:0] right_data_i,
  input  logic [PRIO_BITS-1:0]      right_prio_i,
  output logic                      ins_o,
  output logic                      valid_o,
  output logic [spq_pkg::DataW-1:0] data_o,
  output logic [PRIO_BITS-1:0]      prio_o
);

  logic                      valid_q, valid_d;
  logic [spq_pkg::DataW-1:0] data_q, data_d;
  logic [PRIO_BITS-1:0]      prio_q, prio_d;

  // The new entry belongs in front of an empty cell or of a strictly greater priority.
  assign ins_o = !valid_q || (prio_q > new_prio_i);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (ctrl_i.enq) begin
      if (left_ins_i) begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
        prio_d  = left_prio_i;
      end else if (ins_o) begin
        valid_d = 1'b1;
        data_d  = new_data_i;
        prio_d  = new_prio_i;
      end
    end else if (ctrl_i.deq) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign prio_o  = prio_q;

endmodule

/* hdl/stable_priority_queue.sv */
// Top level of the stable priority queue: a sorted row of cells and the result register.
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one item per cycle while out_ready_i keeps the result register free, since every cell
// compares its priority with the new one at the same time and all cells shift in one step.
// Reset clears all cell valid bits, the entry count and the result valid flag at once,
// so the queue is empty and ready right after reset.
module stable_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DefDepth,
  parameter int unsigned PRIO_BITS = spq_pkg::DefPrioBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned ExtW = PRIO_BITS + spq_pkg::FieldPrioW;
  localparam int unsigned CExtW = CntW + spq_pkg::FieldCountW;

  logic                      valid_w [DEPTH];
  logic [spq_pkg::DataW-1:0] data_w  [DEPTH];
  logic [PRIO_BITS-1:0]      prio_w  [DEPTH];
  logic                      ins_w   [DEPTH];

  logic                in_xfer;
  logic                full, empty;
  spq_pkg::cell_ctrl_t ctrl;
  logic [ExtW-1:0]     in_prio_ext, head_prio_ext;
  logic [PRIO_BITS-1:0] new_prio;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CExtW-1:0]    cnt_ext;
  logic                out_valid_q;
  spq_pkg::out_item_t  out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = valid_w[DEPTH-1];
  assign empty      = !valid_w[0];

  assign ctrl.enq = in_xfer && (in_item_i.op == spq_pkg::OP_ENQ) && !full;
  assign ctrl.deq = in_xfer && (in_item_i.op == spq_pkg::OP_DEQ) && !empty;

  assign in_prio_ext   = {{PRIO_BITS{1'b0}}, in_item_i.prio};
  assign new_prio      = in_prio_ext[PRIO_BITS-1:0];
  assign head_prio_ext = {{spq_pkg::FieldPrioW{1'b0}}, prio_w[0]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_ins, l_valid, r_valid;
    logic [spq_pkg::DataW-1:0] l_data, r_data;
    logic [PRIO_BITS-1:0]      l_prio, r_prio;

    if (i == 0) begin : g_first
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_data  = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_ins   = ins_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_data  = data_w[i-1];
      assign l_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = valid_w[i+1];
      assign r_data  = data_w[i+1];
      assign r_prio  = prio_w[i+1];
    end

    spq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_data_i   (in_item_i.msg_data),
      .new_prio_i   (new_prio),
      .left_ins_i   (l_ins),
      .left_valid_i (l_valid),
      .left_data_i  (l_data),
      .left_prio_i  (l_prio),
      .right_valid_i(r_valid),
      .right_data_i (r_data),
      .right_prio_i (r_prio),
      .ins_o        (ins_w[i]),
      .valid_o      (valid_w[i]),
      .data_o       (data_w[i]),
      .prio_o       (prio_w[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.enq) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.deq) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign cnt_ext = {{spq_pkg::FieldCountW{1'b0}}, cnt_d};

  always_comb begin
    out_d.status   = spq_pkg::ST_OK;
    out_d.out_data = '0;
    out_d.out_prio = '0;
    out_d.count    = cnt_ext[spq_pkg::FieldCountW-1:0];
    case (in_item_i.op)
      spq_pkg::OP_ENQ: begin
        if (full) begin
          out_d.status = spq_pkg::ST_FULL;
        end
      end
      spq_pkg::OP_DEQ: begin
        if (empty) begin
          out_d.status = spq_pkg::ST_EMPTY;
        end else begin
          out_d.out_data = data_w[0];
          out_d.out_prio = head_prio_ext[spq_pkg::FieldPrioW-1:0];
        end
      end
      default: begin
        out_d.status = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(0)) == !valid_w[0])
    else $error("Entry count and head valid bit disagree.");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(DEPTH)) == valid_w[DEPTH-1])
    else $error("Entry count and last valid bit disagree.");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("An input transfer produced no result.");

  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.enq && ctrl.deq))
    else $error("Insert and remove requested in the same cycle.");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for the stable priority queue with a built-in sorted-queue predictor.
module tb;

  localparam int unsigned Depth = spq_pkg::DefDepth;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  spq_pkg::in_item_t  in_item   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  spq_pkg::out_item_t out_item;

  logic signed [spq_pkg::DataW-1:0] model_data [Depth];
  logic [spq_pkg::FieldPrioW-1:0]   model_prio [Depth];
  int unsigned                      model_count = 0;
  spq_pkg::out_item_t               pending_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req     = 0;
  int unsigned stall_left    = 0;
  int unsigned errors        = 0;

  stable_priority_queue #(
    .DEPTH    (Depth),
    .PRIO_BITS(spq_pkg::DefPrioBits)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) begin
      $display("tb: mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // Insert before the first entry with a strictly greater priority, or pop the head.
  function automatic spq_pkg::out_item_t predict_result(input spq_pkg::in_item_t it);
    spq_pkg::out_item_t res;
    int unsigned        pos;
    int unsigned        i;
    res = '0;
    res.status = spq_pkg::ST_OK;
    if (it.op == spq_pkg::OP_ENQ) begin
      if (model_count >= Depth) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = model_count;
        for (i = 0; i < model_count; i++) begin
          if (pos == model_count && model_prio[i] > it.prio) begin
            pos = i;
          end
        end
        for (i = model_count; i > pos; i--) begin
          model_data[i] = model_data[i-1];
          model_prio[i] = model_prio[i-1];
        end
        model_data[pos] = it.msg_data;
        model_prio[pos] = it.prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.out_data = model_data[0];
        res.out_prio = model_prio[0];
        for (i = 1; i < model_count; i++) begin
          model_data[i-1] = model_data[i];
          model_prio[i-1] = model_prio[i];
        end
        model_count--;
      end
    end
    res.count = model_count[spq_pkg::FieldCountW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(predict_result(in_item));
    end
  end

  always @(posedge clk) begin
    spq_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no result expected");
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_item.status, want.status));
        end
        if (out_item.out_data !== want.out_data) begin
          report_mismatch($sformatf("data %0d, expected %0d", out_item.out_data, want.out_data));
        end
        if (out_item.out_prio !== want.out_prio) begin
          report_mismatch($sformatf("prio %0d, expected %0d", out_item.out_prio, want.out_prio));
        end
        if (out_item.count !== want.count) begin
          report_mismatch($sformatf("count %0d, expected %0d", out_item.count, want.count));
        end
      end
    end
  end

  // A requested hold-off keeps ready low until the stall_left countdown runs out.
  always @(posedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input spq_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(input spq_pkg::op_e op, input logic [spq_pkg::DataW-1:0] data,
                         input logic [spq_pkg::FieldPrioW-1:0] prio);
    spq_pkg::in_item_t it;
    it.op       = op;
    it.msg_data = data;
    it.prio     = prio;
    send_item(it);
  endtask

  task automatic test_directed();
    logic [spq_pkg::FieldPrioW-1:0] prios [16];
    logic [spq_pkg::DataW-1:0]      data;
    int                             i;
    prios = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd7,
              8'd7, 8'd200, 8'd1, 8'd128, 8'd64, 8'd64, 8'd254, 8'd0};
    send_op(spq_pkg::OP_DEQ, '1, '1);
    for (i = 0; i < 16; i++) begin
      case (i)
        0:       data = 32'h7FFF_FFFF;
        1:       data = 32'h8000_0000;
        2:       data = '1;
        default: data = (i * 32'h0101_0101) ^ 32'h5A5A_5A5A;
      endcase
      send_op(spq_pkg::OP_ENQ, data, prios[i]);
    end
    send_op(spq_pkg::OP_ENQ, 32'd123, 8'd3);
    for (i = 0; i < 3; i++) begin
      send_op(spq_pkg::OP_DEQ, '1, '1);
    end
    send_op(spq_pkg::OP_ENQ, '0, 8'd128);
  endtask

  // Runs of enqueue-heavy, dequeue-heavy and balanced traffic sweep the fill level.
  task automatic test_random(input int unsigned n_items);
    spq_pkg::in_item_t it;
    int unsigned       enq_pct;
    int unsigned       run_left;
    int unsigned       k;
    run_left = 0;
    enq_pct  = 50;
    for (k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(12, 32);
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      run_left--;
      it.op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      case ($urandom_range(7))
        0:       it.msg_data = '1;
        1:       it.msg_data = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: it.msg_data = $urandom();
      endcase
      case ($urandom_range(3))
        0:       it.prio = 8'($urandom_range(3));
        1:       it.prio = 8'($urandom_range(255));
        2:       it.prio = $urandom_range(1) ? 8'd0 : 8'd255;
        default: it.prio = 8'($urandom_range(120, 130));
      endcase
      send_item(it);
    end
  endtask

  // The receiver holds off while items keep coming, so the result register fills and the block stalls its input.
  task automatic test_backpressure();
    stall_req = 80;
    test_random(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 80;
    test_directed();
    test_random(280);

    send_idle_pct = 80;
    recv_idle_pct = 7;
    test_random(280);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(280);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
test/tb.sv
